// ===== hdl/atws_pkg.sv =====
// ----------------------------------------------------------------------------
// atws_pkg
// shared types and constants for the alarm table with snooze
// ----------------------------------------------------------------------------
package atws_pkg;

	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SLOT_W   = 4;
	localparam int MASK_W   = 16;
	localparam int KIND_W   = 2;
	localparam int SNZ_W    = 6;

	localparam logic [MINUTE_W-1:0] MIN_LAST_OF_HOUR = 6'd59;
	localparam logic [HOUR_W-1:0]   HOUR_LAST_OF_DAY = 5'd23;
	localparam logic [6:0]          MINUTES_PER_HOUR = 7'd60;
	localparam logic [6:0]          MINUTES_TWO_HOURS = 7'd120;
	localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;
	localparam logic [SNZ_W-1:0]    SNOOZE_RESET     = 6'd10;

	// input command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// report kinds
	localparam logic [KIND_W-1:0] RPT_ADDED = 2'd0;
	localparam logic [KIND_W-1:0] RPT_FULL  = 2'd1;
	localparam logic [KIND_W-1:0] RPT_FIRED = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic add;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic pend_valid;
		logic scan_done;
	} ctrl_sts_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                snz;
		logic                last;
	} report_t;

endpackage

// ===== hdl/atws_ctrl.sv =====
// ----------------------------------------------------------------------------
// atws_ctrl
// sequencer for add and tick commands
// ----------------------------------------------------------------------------
module atws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  atws_pkg::ctrl_sts_t sts,
	output atws_pkg::ctrl_cmd_t cmd
);

	atws_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		s_tready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			atws_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = (s_tuser == atws_pkg::CMD_TICK) ? atws_pkg::ST_SCAN
					                                           : atws_pkg::ST_ADD;
				end
			end
			atws_pkg::ST_ADD: begin
				if (sts.out_free) begin
					cmd.add   = 1'b1;
					state_nxt = atws_pkg::ST_IDLE;
				end
			end
			atws_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = atws_pkg::ST_FIN;
				end
			end
			atws_pkg::ST_FIN: begin
				// last pending report goes out with last set, then the clock moves
				if (!sts.pend_valid || sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = atws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = atws_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/atws_dp.sv =====
// ----------------------------------------------------------------------------
// atws_dp
// alarm table, minute clock, slot scan pipeline and output register
// ----------------------------------------------------------------------------
module atws_dp #(
	parameter int ALARM_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  atws_pkg::ctrl_cmd_t                 cmd,
	output atws_pkg::ctrl_sts_t                 sts,
	input  logic                                in_kind,
	input  logic [atws_pkg::HOUR_W-1:0]         in_hour,
	input  logic [atws_pkg::MINUTE_W-1:0]       in_minute,
	input  logic [atws_pkg::MASK_W-1:0]         in_mask,
	input  logic                                cfg_valid,
	input  logic [atws_pkg::SNZ_W-1:0]          cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output atws_pkg::report_t                   out_rpt
);

	localparam int CW = $clog2(ALARM_SLOTS + 1);
	localparam int IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam logic [CW-1:0] NSLOT = CW'(ALARM_SLOTS);

	// alarm table
	logic [atws_pkg::HOUR_W-1:0]   hour_mem [ALARM_SLOTS];
	logic [atws_pkg::MINUTE_W-1:0] min_mem  [ALARM_SLOTS];
	logic                          snz_mem  [ALARM_SLOTS];
	logic [ALARM_SLOTS-1:0]        armed_q;
	logic [CW-1:0]                 count_q;

	logic [atws_pkg::HOUR_W-1:0]   clk_hour_q;
	logic [atws_pkg::MINUTE_W-1:0] clk_min_q;
	logic [atws_pkg::SNZ_W-1:0]    snooze_q;

	// latched item
	logic                          item_kind_q;
	logic [atws_pkg::HOUR_W-1:0]   item_hour_q;
	logic [atws_pkg::MINUTE_W-1:0] item_min_q;
	logic [atws_pkg::MASK_W-1:0]   mask_sh_q;

	// scan pipeline
	logic [CW-1:0]                 idx_q;
	logic                          valid_s1;
	logic [CW-1:0]                 idx_s1;
	logic [atws_pkg::HOUR_W-1:0]   rd_hour_s1;
	logic [atws_pkg::MINUTE_W-1:0] rd_min_s1;
	logic                          rd_snz_s1;

	atws_pkg::report_t pend_q, out_q, out_nxt, fire_rpt;
	logic              pend_valid_q, out_valid_q, out_load;

	logic hit_s1, stall, adv, push, take, rd_en, add_wr, snz_wr, tbl_full;
	logic [6:0]                    snz_tot;
	logic [atws_pkg::MINUTE_W-1:0] snz_min;
	logic [atws_pkg::HOUR_W-1:0]   snz_hsum, snz_hour;
	logic [1:0]                    snz_hadd;

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.pend_valid = pend_valid_q;
	assign sts.scan_done  = (idx_q == NSLOT) && !valid_s1;

	assign tbl_full = (count_q >= NSLOT);
	assign add_wr   = cmd.add && !tbl_full;

	assign hit_s1 = valid_s1 && (idx_s1 < count_q) && armed_q[idx_s1[IW-1:0]]
	                && (rd_hour_s1 == clk_hour_q) && (rd_min_s1 == clk_min_q);
	assign stall  = hit_s1 && pend_valid_q && !sts.out_free;
	assign adv    = cmd.scan && !stall;
	assign push   = adv && hit_s1;
	assign take   = mask_sh_q[0];
	assign rd_en  = adv && (idx_q < NSLOT);
	assign snz_wr = push && rd_snz_s1 && take;

	// snooze: minute plus interval with carry into hour and day wrap
	always_comb begin
		snz_tot = {1'b0, rd_min_s1} + {1'b0, snooze_q};
		if (snz_tot >= atws_pkg::MINUTES_TWO_HOURS) begin
			snz_min  = atws_pkg::MINUTE_W'(snz_tot - atws_pkg::MINUTES_TWO_HOURS);
			snz_hadd = 2'd2;
		end else if (snz_tot >= atws_pkg::MINUTES_PER_HOUR) begin
			snz_min  = atws_pkg::MINUTE_W'(snz_tot - atws_pkg::MINUTES_PER_HOUR);
			snz_hadd = 2'd1;
		end else begin
			snz_min  = atws_pkg::MINUTE_W'(snz_tot);
			snz_hadd = 2'd0;
		end
		snz_hsum = rd_hour_s1 + {3'b000, snz_hadd};
		snz_hour = (snz_hsum >= atws_pkg::HOURS_PER_DAY)
		           ? snz_hsum - atws_pkg::HOURS_PER_DAY : snz_hsum;
	end

	always_comb begin
		fire_rpt.kind   = atws_pkg::RPT_FIRED;
		fire_rpt.slot   = atws_pkg::SLOT_W'(idx_s1);
		fire_rpt.hour   = rd_hour_s1;
		fire_rpt.minute = rd_min_s1;
		fire_rpt.snz    = rd_snz_s1;
		fire_rpt.last   = 1'b0;
	end

	always_comb begin
		out_load = 1'b0;
		out_nxt  = pend_q;
		if (cmd.add) begin
			out_load       = 1'b1;
			out_nxt.kind   = tbl_full ? atws_pkg::RPT_FULL : atws_pkg::RPT_ADDED;
			out_nxt.slot   = tbl_full ? '0 : atws_pkg::SLOT_W'(count_q);
			out_nxt.hour   = item_hour_q;
			out_nxt.minute = item_min_q;
			out_nxt.snz    = item_kind_q;
			out_nxt.last   = 1'b1;
		end else if (push && pend_valid_q) begin
			out_load     = 1'b1;
			out_nxt.last = 1'b0;
		end else if (cmd.finish && pend_valid_q) begin
			out_load     = 1'b1;
			out_nxt.last = 1'b1;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (add_wr) begin
			hour_mem[count_q[IW-1:0]] <= item_hour_q;
			min_mem[count_q[IW-1:0]]  <= item_min_q;
			snz_mem[count_q[IW-1:0]]  <= item_kind_q;
		end else if (snz_wr) begin
			hour_mem[idx_s1[IW-1:0]] <= snz_hour;
			min_mem[idx_s1[IW-1:0]]  <= snz_min;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_hour_s1 <= hour_mem[idx_q[IW-1:0]];
			rd_min_s1  <= min_mem[idx_q[IW-1:0]];
			rd_snz_s1  <= snz_mem[idx_q[IW-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_kind_q <= in_kind;
			item_hour_q <= in_hour;
			item_min_q  <= in_minute;
		end
		if (adv) begin
			idx_s1 <= idx_q;
		end
		if (push) begin
			pend_q <= fire_rpt;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= '0;
			count_q      <= '0;
			clk_hour_q   <= '0;
			clk_min_q    <= '0;
			snooze_q     <= atws_pkg::SNOOZE_RESET;
			idx_q        <= '0;
			valid_s1     <= 1'b0;
			mask_sh_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				snooze_q <= cfg_data;
			end
			if (cmd.load) begin
				idx_q     <= '0;
				valid_s1  <= 1'b0;
				mask_sh_q <= in_mask;
			end else if (adv) begin
				valid_s1 <= (idx_q < NSLOT);
				if (idx_q < NSLOT) begin
					idx_q <= idx_q + 1'b1;
				end
				if (valid_s1) begin
					mask_sh_q <= {1'b0, mask_sh_q[atws_pkg::MASK_W-1:1]};
				end
			end
			if (add_wr) begin
				armed_q[count_q[IW-1:0]] <= 1'b1;
				count_q                  <= count_q + 1'b1;
			end
			if (push && rd_snz_s1 && !take) begin
				armed_q[idx_s1[IW-1:0]] <= 1'b0;
			end
			if (push) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (clk_min_q == atws_pkg::MIN_LAST_OF_HOUR) begin
					clk_min_q  <= '0;
					clk_hour_q <= (clk_hour_q == atws_pkg::HOUR_LAST_OF_DAY)
					              ? '0 : clk_hour_q + 1'b1;
				end else begin
					clk_min_q <= clk_min_q + 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rpt   = out_q;

endmodule

// ===== hdl/alarm_table_with_snooze_top.sv =====
// ----------------------------------------------------------------------------
// alarm_table_with_snooze_top
// minute clock with an alarm table, fire reports and per-tick snooze control
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one command word: s_tuser selects add (0) or tick (1).
//   an add stores the alarm in the next free slot and answers with one word
//   (added or table full), last set. a tick reports every armed alarm that
//   matches the current time in slot order, tlast on the final one, then the
//   clock moves one minute. a tick with nothing firing gives no word. cfg_* writes
//   the snooze interval in minutes (reset 10); the user writes only while idle, unchecked.
// sequence
//   add: the item is latched on accept; the ADD state waits for a free output,
//   then stores it if there is room and loads the result word. tick: the scan
//   reads one slot per cycle unless stalled; commands are taken only when idle.
// reset
//   clock at 00:00, table empty, no alarm armed, output word not valid.
// stalls
//   results sit in an output register with one pending report behind it;
//   when both are held and another slot fires, the slot scan pauses until m_tready returns.
// ----------------------------------------------------------------------------
module alarm_table_with_snooze_top #(
	parameter int ALARM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // alarm_kind, alarm_hour[5], alarm_minute[6], snooze_mask[16]
	input  logic        s_tuser,   // command
	// report stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot[4], fire_hour[5], fire_minute[6], snoozeable
	output logic [1:0]  m_tuser,   // report_kind
	output logic        m_tlast,   // last_report
	// snooze interval register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	atws_pkg::ctrl_cmd_t cmd;
	atws_pkg::ctrl_sts_t sts;
	atws_pkg::report_t   rpt;

	// register write always taken at once
	assign cfg_ready = 1'b1;

	atws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	atws_dp #(
		.ALARM_SLOTS (ALARM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tdata[0]),
		.in_hour   (s_tdata[5:1]),
		.in_minute (s_tdata[11:6]),
		.in_mask   (s_tdata[27:12]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_rpt   (rpt)
	);

	// output word packing
	assign m_tdata = {rpt.snz, rpt.minute, rpt.hour, rpt.slot};
	assign m_tuser = rpt.kind;
	assign m_tlast = rpt.last;

	// an accepted command keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while previous one still in work");

	// controller issues at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.add, cmd.scan, cmd.finish}))
		else $error("overlapping datapath commands");

	// finishing a tick returns to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> s_tready)
		else $error("not idle after tick finish");

	// an add result never overwrites a word that is still held
	a_add_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add |-> (!m_tvalid || m_tready))
		else $error("add result would overwrite held output word");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the alarm table with snooze: a clocked driver feeds
// command words from a queue, a local copy of the clock and alarm table works
// out the expected report words, and a clocked monitor checks each one
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ALARM_SLOTS   = 16;
	localparam int SETTLE_CYCLES = 2 * ALARM_SLOTS + 8;   // one slow tick scan and then some

	localparam logic ALARM_REPEAT = 1'b0;
	localparam logic ALARM_SNOOZE = 1'b1;

	// one command word as the driver sees it
	typedef struct {
		logic                          cmd;
		logic                          kind;
		logic [atws_pkg::HOUR_W-1:0]   hour;
		logic [atws_pkg::MINUTE_W-1:0] minute;
		logic [atws_pkg::MASK_W-1:0]   mask;
	} cmd_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // alarm_kind, alarm_hour[5], alarm_minute[6], snooze_mask[16]
	logic        s_tuser   = 1'b0; // command
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // slot[4], fire_hour[5], fire_minute[6], snoozeable
	logic [1:0]  m_tuser;          // report_kind
	logic        m_tlast;          // last_report
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data  = '0;

	// words waiting for the driver, reports waiting for the monitor
	cmd_word_t         pending_words[$];
	atws_pkg::report_t expected_reports[$];
	cmd_word_t         word_out;
	atws_pkg::report_t seen_rpt;
	atws_pkg::report_t want_rpt;

	// idle and stall odds in percent, changed per phase
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int error_count    = 0;

	// alarm clock as the bench predicts it
	logic [atws_pkg::HOUR_W-1:0]   clk_hour_m;
	logic [atws_pkg::MINUTE_W-1:0] clk_minute_m;
	logic [atws_pkg::SNZ_W-1:0]    snooze_len_m;
	int                            stored_alarms;
	logic                          armed_m  [ALARM_SLOTS];
	logic                          snz_m    [ALARM_SLOTS];
	logic [atws_pkg::HOUR_W-1:0]   alarm_hr [ALARM_SLOTS];
	logic [atws_pkg::MINUTE_W-1:0] alarm_mn [ALARM_SLOTS];

	alarm_table_with_snooze_top #(
		.ALARM_SLOTS(ALARM_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// apply one accepted command word to the table and queue the reports it causes
	task automatic predict_alarm_reports(input logic cmd, input logic kind,
			input logic [atws_pkg::HOUR_W-1:0] hr_in,
			input logic [atws_pkg::MINUTE_W-1:0] mn_in,
			input logic [atws_pkg::MASK_W-1:0] mask);
		atws_pkg::report_t rpt;
		int                fired;
		int                total;
		int                hh;
		int                s;
		fired = 0;
		if (cmd == atws_pkg::CMD_ADD) begin
			rpt.hour   = hr_in;
			rpt.minute = mn_in;
			rpt.snz    = kind;
			rpt.last   = 1'b1;
			if (stored_alarms < ALARM_SLOTS) begin
				// next free slot, time kept as given even if out of range
				rpt.kind = atws_pkg::RPT_ADDED;
				rpt.slot = atws_pkg::SLOT_W'(stored_alarms);
				armed_m[stored_alarms]  = 1'b1;
				snz_m[stored_alarms]    = kind;
				alarm_hr[stored_alarms] = hr_in;
				alarm_mn[stored_alarms] = mn_in;
				stored_alarms++;
			end else begin
				// table full: echo the request, slot zero, nothing stored
				rpt.kind = atws_pkg::RPT_FULL;
				rpt.slot = '0;
			end
			expected_reports.insert(expected_reports.size(), rpt);
		end else begin
			// scan in slot order against the time before the advance
			for (s = 0; s < stored_alarms; s++) begin
				if (armed_m[s] && alarm_hr[s] == clk_hour_m
						&& alarm_mn[s] == clk_minute_m) begin
					rpt.kind   = atws_pkg::RPT_FIRED;
					rpt.slot   = atws_pkg::SLOT_W'(s);
					rpt.hour   = alarm_hr[s];
					rpt.minute = alarm_mn[s];
					rpt.snz    = snz_m[s];
					rpt.last   = 1'b0;
					expected_reports.insert(expected_reports.size(), rpt);
					fired++;
					if (snz_m[s]) begin
						if (mask[s]) begin
							// push forward with carry into the hour and wrap at midnight
							total = int'(alarm_mn[s]) + int'(snooze_len_m);
							hh    = int'(alarm_hr[s]);
							while (total >= 60) begin
								total -= 60;
								hh++;
							end
							while (hh >= 24)
								hh -= 24;
							alarm_hr[s] = atws_pkg::HOUR_W'(hh);
							alarm_mn[s] = atws_pkg::MINUTE_W'(total);
						end else begin
							armed_m[s] = 1'b0;
						end
					end
				end
			end
			if (fired > 0)
				expected_reports[expected_reports.size() - 1].last = 1'b1;
			// the clock moves on whether or not anything fired
			if (clk_minute_m == atws_pkg::MIN_LAST_OF_HOUR) begin
				clk_minute_m = '0;
				clk_hour_m   = (clk_hour_m == atws_pkg::HOUR_LAST_OF_DAY)
				               ? '0 : clk_hour_m + 1'b1;
			end else begin
				clk_minute_m = clk_minute_m + 1'b1;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t ns  error: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// driver: one command word at a time, with random idle cycles
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// a word taken at this edge goes into the predictor first
			if (s_tvalid && s_tready)
				predict_alarm_reports(s_tuser, s_tdata[0], s_tdata[5:1], s_tdata[11:6],
					s_tdata[27:12]);
			// the bus is free once the current word is gone
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					word_out = pending_words.pop_front();
					s_tuser  <= word_out.cmd;
					s_tdata  <= {4'b0, word_out.mask, word_out.minute, word_out.hour,
						word_out.kind};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: random back-pressure, each report word against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
			if (m_tvalid && m_tready) begin
				seen_rpt.kind   = m_tuser;
				seen_rpt.slot   = m_tdata[3:0];
				seen_rpt.hour   = m_tdata[8:4];
				seen_rpt.minute = m_tdata[14:9];
				seen_rpt.snz    = m_tdata[15];
				seen_rpt.last   = m_tlast;
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("report word with none pending, kind %0d slot %0d",
						seen_rpt.kind, seen_rpt.slot));
				end else begin
					want_rpt = expected_reports.pop_front();
					check_field("report_kind", seen_rpt.kind, want_rpt.kind);
					check_field("slot", seen_rpt.slot, want_rpt.slot);
					check_field("fire_hour", seen_rpt.hour, want_rpt.hour);
					check_field("fire_minute", seen_rpt.minute, want_rpt.minute);
					check_field("snoozeable", seen_rpt.snz, want_rpt.snz);
					check_field("last_report", seen_rpt.last, want_rpt.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// add command; the mask bits ride along with random content
	task automatic queue_add(input logic kind, input logic [atws_pkg::HOUR_W-1:0] hour,
			input logic [atws_pkg::MINUTE_W-1:0] minute);
		cmd_word_t w;
		w.cmd    = atws_pkg::CMD_ADD;
		w.kind   = kind;
		w.hour   = hour;
		w.minute = minute;
		w.mask   = atws_pkg::MASK_W'($urandom);
		pending_words.insert(pending_words.size(), w);
	endtask

	// tick command; kind and time fields are don't-care so they get noise
	task automatic queue_tick(input logic [atws_pkg::MASK_W-1:0] mask);
		cmd_word_t w;
		w.cmd    = atws_pkg::CMD_TICK;
		w.kind   = 1'($urandom);
		w.hour   = atws_pkg::HOUR_W'($urandom);
		w.minute = atws_pkg::MINUTE_W'($urandom);
		w.mask   = mask;
		pending_words.insert(pending_words.size(), w);
	endtask

	// mostly keep snoozeable alarms alive so they keep coming back
	function automatic logic [atws_pkg::MASK_W-1:0] pick_mask();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return '1;
		else if (r < 92)
			return ~(atws_pkg::MASK_W'(1) << $urandom_range(atws_pkg::MASK_W - 1));
		else
			return atws_pkg::MASK_W'($urandom);
	endfunction

	// table is full by now, so adds only check the full echo
	task automatic run_random(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 15)
				queue_add(1'($urandom), atws_pkg::HOUR_W'($urandom),
					atws_pkg::MINUTE_W'($urandom));
			else
				queue_tick(pick_mask());
		end
	endtask

	// hold the sender until every predicted report has been seen
	task automatic quiesce();
		while (pending_words.size() != 0 || s_tvalid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// register write while the block is idle, model follows at the handshake
	task automatic write_snooze(input logic [atws_pkg::SNZ_W-1:0] minutes);
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data  <= minutes;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		snooze_len_m = minutes;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int s;
		clk_hour_m    = '0;
		clk_minute_m  = '0;
		snooze_len_m  = atws_pkg::SNOOZE_RESET;
		stored_alarms = 0;
		for (s = 0; s < ALARM_SLOTS; s++) begin
			armed_m[s]  = 1'b0;
			snz_m[s]    = 1'b0;
			alarm_hr[s] = '0;
			alarm_mn[s] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill the table with a planned set, snooze interval at reset value
		queue_add(ALARM_SNOOZE, 5'd0, 6'd0);        // snoozed on the first tick
		queue_add(ALARM_REPEAT, 5'd0, 6'd0);        // fires alongside it
		queue_add(ALARM_SNOOZE, 5'd31, 6'd63);      // out of range, never fires
		queue_add(ALARM_REPEAT, 5'd23, 6'd59);      // last minute of the day
		queue_add(ALARM_SNOOZE, 5'd0, 6'd1);        // disarmed by a zero mask bit
		queue_add(ALARM_SNOOZE, 5'd23, 6'd55);      // late evening, stays quiet
		for (s = 6; s < ALARM_SLOTS; s++)
			queue_add((s == 7 || s == 12) ? ALARM_REPEAT : ALARM_SNOOZE, 5'd0, 6'd3);
		queue_add(ALARM_REPEAT, 5'd23, 6'd59);      // table full
		queue_add(ALARM_SNOOZE, 5'd31, 6'd63);      // full, out-of-range echo
		queue_tick('1);                             // 00:00 two fire
		queue_tick('0);                             // 00:01 one fires and disarms
		queue_tick('0);                             // 00:02 nothing fires
		queue_tick(16'hffbf);                       // 00:03 ten fire, slot 6 disarmed
		queue_tick('0);                             // 00:04 nothing

		// snooze of 59 minutes, no idling
		write_snooze(6'd59);
		run_random(120);

		// snooze of one minute: snoozed alarms fire again on the next tick; sender mostly idle
		write_snooze(6'd1);
		src_idle_pct = 86;
		run_random(30);

		// zero snooze keeps the alarm in place; receiver mostly stalling
		write_snooze(6'd0);
		src_idle_pct   = 0;
		sink_stall_pct = 86;
		run_random(80);

		// random interval, both sides idling, with a full drain halfway
		write_snooze(atws_pkg::SNZ_W'($urandom_range(2, 58)));
		src_idle_pct   = 28;
		sink_stall_pct = 28;
		run_random(70);
		quiesce();
		run_random(70);

		// largest register value, snooze carries across two hours
		write_snooze(6'd63);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		run_random(130);

		// drain, then give a stray word time to show up
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
